@@ src/gate_step_sequencer_track_defines.svh @@
// Assertion macros for the gate step sequencer track.
// Used by the port checker; no other dependencies.
`ifndef GATE_STEP_SEQUENCER_TRACK_DEFINES_SVH
`define GATE_STEP_SEQUENCER_TRACK_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GSST_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gsst assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GSST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gsst assertion failed");

`endif

@@ src/gsst_pkg.sv @@
// Shared types and constants for the gate step sequencer track.
// No dependencies.
`default_nettype none

package gsst_pkg;

  localparam int MaxSteps = 64;
  localparam int PosW     = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
  localparam int LenW     = $clog2(MaxSteps + 1);

  typedef enum logic [1:0] {
    KindPlay     = 2'd0,
    KindRecStart = 2'd1,
    KindRecStep  = 2'd2,
    KindRecStop  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  clock_rise;
    logic  clock_fall;
    logic  reset_rise;
    logic  reset_press;
    logic  modifier_held;
    logic  track_press;
    logic  rec_silent;
    logic  rec_half;
    logic  rec_full;
  } in_item_t;

  typedef struct packed {
    logic       gate_out;
    logic       play_enabled;
    logic [5:0] current_step;
    logic [6:0] recorded_steps;
  } out_item_t;

  // Gate bits of one step: on after the rising edge, on after the falling edge.
  typedef struct packed {
    logic rise;
    logic fall;
  } step_bits_t;

  typedef struct packed {
    logic            en;
    logic [PosW-1:0] addr;
    step_bits_t      data;
  } mem_wr_t;

endpackage

`default_nettype wire

@@ src/gsst_in_stage.sv @@
// Input register of the gate step sequencer track.
// Depends on gsst_pkg.
`default_nettype none

module gsst_in_stage import gsst_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  input  wire logic     adv_i,
  output logic          vld_o,
  output in_item_t      data_o
);

  logic     vld_q;
  logic     vld_d;
  in_item_t data_q;

  assign in_ready_o = !vld_q || adv_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

@@ src/gsst_pat_mem.sv @@
// Pattern store: gate bits per step, one write and one registered read a cycle.
// Entries at or above the fill count read as silent unless written in the cycle of the read. Depends on gsst_pkg.
`default_nettype none

module gsst_pat_mem import gsst_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mem_wr_t         wr_i,
  input  wire logic            rd_en_i,
  input  wire logic [PosW-1:0] rd_addr_i,
  output step_bits_t           rd_data_o
);

  step_bits_t            mem_q [MaxSteps];
  step_bits_t            mem_rd_q;
  step_bits_t            fwd_q;
  logic                  hit_q;
  logic                  filled_q;
  logic [LenW-1:0]       fill_q;
  logic [LenW-1:0]       fill_d;

  // Writes land at the pattern length, which never exceeds the fill count.
  always_comb begin
    fill_d = fill_q;
    if (wr_i.en && (LenW'(wr_i.addr) == fill_q)) begin
      fill_d = fill_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mem_rd_q <= mem_q[rd_addr_i];
      fwd_q    <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      hit_q    <= 1'b0;
      filled_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        hit_q    <= wr_i.en && (wr_i.addr == rd_addr_i);
        filled_q <= LenW'(rd_addr_i) < fill_q;
      end
    end
  end

  assign rd_data_o = hit_q    ? fwd_q    :
                     filled_q ? mem_rd_q : '0;

endmodule

`default_nettype wire

@@ src/gsst_core.sv @@
// Track state update and result register of the gate step sequencer track.
// Depends on gsst_pkg; reads step bits from gsst_pat_mem.
`default_nettype none

module gsst_core import gsst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_vld_i,
  input  wire in_item_t   in_data_i,
  input  wire step_bits_t nxt_bits_i,
  output logic            adv_o,
  output mem_wr_t         wr_o,
  output logic [PosW-1:0] rd_addr_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output out_item_t       out_data_o
);

  logic [LenW-1:0] len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            pend_q, pend_d;
  logic            unm_q, unm_d;
  logic            gate_q, gate_d;
  step_bits_t      cur_q, cur_d;
  step_bits_t      zero_q, zero_d;
  logic            out_vld_q;
  out_item_t       out_q;
  logic            pend_now;
  logic [LenW-1:0] pos_inc;
  logic [LenW-1:0] rd_inc;
  mem_wr_t         wr;

  assign adv_o = in_vld_i && (!out_vld_q || out_ready_i);

  always_comb begin
    len_d    = len_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    unm_d    = unm_q;
    gate_d   = gate_q;
    cur_d    = cur_q;
    zero_d   = zero_q;
    wr       = '0;
    pend_now = pend_q;
    pos_inc  = LenW'(pos_q) + LenW'(1);
    unique case (in_data_i.kind)
      KindPlay: begin
        unm_d = unm_q ^ (in_data_i.modifier_held & in_data_i.track_press);
        if (len_q == '0) begin
          gate_d = 1'b0;
        end else begin
          pend_now = pend_q | in_data_i.reset_rise | in_data_i.reset_press;
          pend_d   = pend_now;
          if (in_data_i.clock_rise) begin
            if (pend_now) begin
              pos_d  = '0;
              cur_d  = zero_q;
              pend_d = 1'b0;
            end else if (pos_inc >= len_q) begin
              pos_d = '0;
              cur_d = zero_q;
            end else begin
              pos_d = PosW'(pos_inc);
              cur_d = nxt_bits_i;
            end
            gate_d = unm_d & cur_d.rise;
          end
          if (in_data_i.clock_fall) begin
            gate_d = unm_d & cur_d.fall;
          end
        end
      end
      KindRecStart: begin
        len_d  = '0;
        gate_d = 1'b0;
      end
      KindRecStep: begin
        if ((len_q < LenW'(MaxSteps)) &&
            (in_data_i.rec_silent || in_data_i.rec_half || in_data_i.rec_full)) begin
          wr.en   = 1'b1;
          wr.addr = PosW'(len_q);
          if (in_data_i.rec_silent) begin
            wr.data = '{rise: 1'b0, fall: 1'b0};
          end else if (in_data_i.rec_half) begin
            wr.data = '{rise: 1'b1, fall: 1'b0};
          end else begin
            wr.data = '{rise: 1'b1, fall: 1'b1};
          end
          len_d = len_q + LenW'(1);
          // keep the cached copies in step with the store
          if (wr.addr == pos_q) begin
            cur_d = wr.data;
          end
          if (len_q == '0) begin
            zero_d = wr.data;
          end
        end
      end
      KindRecStop: begin
        pend_d = 1'b1;
      end
      default: begin
        pend_d = pend_q;
      end
    endcase
  end

  // Prefetch the step after the new position for the next rising edge.
  assign rd_inc    = LenW'(pos_d) + LenW'(1);
  assign rd_addr_o = (rd_inc == LenW'(MaxSteps)) ? '0 : PosW'(rd_inc);

  always_comb begin
    wr_o    = wr;
    wr_o.en = wr.en & adv_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      pos_q     <= '0;
      pend_q    <= 1'b0;
      unm_q     <= 1'b1;
      gate_q    <= 1'b0;
      cur_q     <= '0;
      zero_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv_o) begin
        len_q     <= len_d;
        pos_q     <= pos_d;
        pend_q    <= pend_d;
        unm_q     <= unm_d;
        gate_q    <= gate_d;
        cur_q     <= cur_d;
        zero_q    <= zero_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_q.gate_out       <= gate_d & unm_d;
      out_q.play_enabled   <= unm_d;
      out_q.current_step   <= 6'(pos_d);
      out_q.recorded_steps <= 7'(len_d);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ src/gate_step_sequencer_track.sv @@
// Gate step sequencer track, top level.
// Path: a request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while results are taken, set by the single state
// update between the input register and the result register; the pattern store read is prefetched.
// Reset: asynchronous, active low; the pattern reads as silent through a fill
// count, so no clearing pass is needed and requests are taken right after reset.
`default_nettype none

module gate_step_sequencer_track import gsst_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  logic            adv;
  logic            in_vld;
  in_item_t        in_data;
  mem_wr_t         mem_wr;
  logic [PosW-1:0] rd_addr;
  step_bits_t      nxt_bits;

  gsst_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .vld_o      (in_vld),
    .data_o     (in_data)
  );

  gsst_pat_mem u_pat_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (mem_wr),
    .rd_en_i   (adv),
    .rd_addr_i (rd_addr),
    .rd_data_o (nxt_bits)
  );

  gsst_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_vld_i    (in_vld),
    .in_data_i   (in_data),
    .nxt_bits_i  (nxt_bits),
    .adv_o       (adv),
    .wr_o        (mem_wr),
    .rd_addr_o   (rd_addr),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ src/gsst_checker.sv @@
// Port-level checker for the gate step sequencer track, bound to the top level.
// Depends on gsst_pkg and gate_step_sequencer_track_defines.svh.
`default_nettype none
`include "gate_step_sequencer_track_defines.svh"

module gsst_checker import gsst_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // hold a stalled request
  `GSST_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_data_i))
  // hold a stalled result
  `GSST_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // a muted track never drives its gate
  `GSST_ASSERT_IMPLY(a_gate_muted, out_valid_o && out_data_o.gate_out, out_data_o.play_enabled)
  `GSST_ASSERT_IMPLY(a_len_bound, out_valid_o, int'(out_data_o.recorded_steps) <= MaxSteps)
  // a result appears only after a request was taken
  `GSST_ASSERT_IMPLY(a_no_phantom, $rose(out_valid_o), $past(in_acc, 2))

endmodule

bind gate_step_sequencer_track gsst_checker u_gsst_checker (.*);

`default_nettype wire

@@ bench/gate_step_sequencer_track_tb.sv @@
// Testbench for gate_step_sequencer_track: directed and random requests, checked
// against a cycle-free model of one sequencer track. Depends on gsst_pkg and the RTL.
`timescale 1ns / 100ps

module gate_step_sequencer_track_tb import gsst_pkg::*; ();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 320;

  // Request waiting to be driven, tagged with its idling phase.
  typedef struct packed {
    logic       hold;
    logic [1:0] phase;
    in_item_t   item;
  } pending_req_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  pending_req_t req_q[$];
  out_item_t    expected_view_q[$];
  pending_req_t next_req;
  out_item_t    want;
  logic [1:0]   drive_phase = 2'd0;

  // Fill-side bookkeeping.
  logic [1:0]  fill_phase = 2'd0;
  logic        hold_next  = 1'b0;
  int unsigned phase_count;

  int unsigned error_count   = 0;
  int unsigned accepted      = 0;
  int unsigned checked       = 0;
  int unsigned full_rejects  = 0;
  int unsigned wraps         = 0;
  int unsigned cycles        = 0;

  // Track model state.
  logic       rise_mem [MaxSteps];
  logic       fall_mem [MaxSteps];
  logic [6:0] trk_len;
  logic [5:0] trk_pos;
  logic       trk_pend;
  logic       trk_unmuted;
  logic       trk_gate;

  gate_step_sequencer_track u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit idle_roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic out_item_t advance_track(in_item_t it);
    out_item_t  o;
    logic [6:0] nxt;
    case (it.kind)
      KindPlay: begin
        // mute toggle comes first, even on an empty pattern
        if (it.modifier_held && it.track_press) trk_unmuted = !trk_unmuted;
        if (trk_len == 7'd0) begin
          trk_gate = 1'b0;
        end else begin
          if (it.reset_rise || it.reset_press) trk_pend = 1'b1;
          if (it.clock_rise) begin
            if (trk_pend) begin
              trk_pos  = '0;
              trk_pend = 1'b0;
            end else begin
              nxt = {1'b0, trk_pos} + 7'd1;
              if (trk_len <= nxt) begin
                trk_pos = '0;
                wraps++;
              end else begin
                trk_pos = nxt[5:0];
              end
            end
            trk_gate = trk_unmuted && rise_mem[trk_pos];
          end
          // the fall bit is read even past the recorded length
          if (it.clock_fall) trk_gate = trk_unmuted && fall_mem[trk_pos];
        end
      end
      KindRecStart: begin
        trk_len  = '0;
        trk_gate = 1'b0;
      end
      KindRecStep: begin
        if (trk_len >= 7'(MaxSteps)) begin
          full_rejects++;
        end else if (it.rec_silent || it.rec_half || it.rec_full) begin
          rise_mem[trk_len[5:0]] = !it.rec_silent;
          fall_mem[trk_len[5:0]] = !it.rec_silent && !it.rec_half;
          trk_len = trk_len + 7'd1;
        end
      end
      default: trk_pend = 1'b1;
    endcase
    o.gate_out       = trk_gate && trk_unmuted;
    o.play_enabled   = trk_unmuted;
    o.current_step   = trk_pos;
    o.recorded_steps = trk_len;
    return o;
  endfunction

  task automatic push_req(in_item_t it);
    pending_req_t p;
    p.hold  = hold_next;
    p.phase = fill_phase;
    p.item  = it;
    hold_next = 1'b0;
    req_q.push_back(p);
    phase_count++;
  endtask

  task automatic push_play(logic r, logic f, logic rr, logic rp, logic m, logic t);
    in_item_t it;
    it = '0;
    it.kind          = KindPlay;
    it.clock_rise    = r;
    it.clock_fall    = f;
    it.reset_rise    = rr;
    it.reset_press   = rp;
    it.modifier_held = m;
    it.track_press   = t;
    push_req(it);
  endtask

  task automatic push_rec(logic s, logic h, logic f);
    in_item_t it;
    it = '0;
    it.kind       = KindRecStep;
    it.rec_silent = s;
    it.rec_half   = h;
    it.rec_full   = f;
    push_req(it);
  endtask

  task automatic push_kind(kind_e k);
    in_item_t it;
    it = '0;
    it.kind = k;
    push_req(it);
  endtask

  // Random play tick; unused record fields get random values as well.
  task automatic push_rand_play(int unsigned rise_pct);
    in_item_t it;
    it = in_item_t'($urandom());
    it.kind          = KindPlay;
    it.clock_rise    = idle_roll(rise_pct);
    it.clock_fall    = idle_roll(50);
    it.reset_rise    = idle_roll(5);
    it.reset_press   = idle_roll(5);
    it.modifier_held = idle_roll(20);
    it.track_press   = idle_roll(20);
    push_req(it);
  endtask

  task automatic push_rand_rec();
    in_item_t it;
    it = in_item_t'($urandom());
    it.kind       = KindRecStep;
    it.rec_silent = ($urandom_range(0, 3) == 0);
    it.rec_half   = ($urandom_range(0, 2) == 0);
    it.rec_full   = ($urandom_range(0, 1) == 1);
    push_req(it);
  endtask

  task automatic fill_random_phase();
    int unsigned pick;
    int unsigned n;
    phase_count = 0;
    while (phase_count < PhaseItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 5) == 0) begin
          n = $urandom_range(70, 90);
          repeat (n) push_rand_play(75);
        end else begin
          n = $urandom_range(5, 30);
          repeat (n) push_rand_play(50);
        end
      end else if (pick < 85) begin
        push_kind(KindRecStart);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
        repeat (n) push_rand_rec();
        // leave recording open now and then
        if ($urandom_range(0, 4) != 0) push_kind(KindRecStop);
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) push_req(in_item_t'($urandom()));
      end
    end
  endtask

  task automatic fill_directed();
    in_item_t it;
    // empty pattern: mute toggles, clock and reset ignored
    push_play(1, 1, 1, 1, 1, 1);
    push_play(0, 0, 0, 0, 1, 1);
    // start recording with every unused field set
    it = '1;
    it.kind = KindRecStart;
    push_req(it);
    push_rec(0, 0, 0);
    push_rec(1, 1, 1);
    push_rec(0, 1, 1);
    push_rec(0, 0, 1);
    push_rec(0, 1, 0);
    push_kind(KindRecStop);
    push_play(1, 0, 0, 0, 0, 0);
    push_play(1, 0, 0, 0, 0, 0);
    push_play(0, 1, 0, 0, 0, 0);
    push_play(1, 1, 0, 0, 0, 0);
    push_play(1, 0, 0, 0, 0, 0);
    push_play(1, 0, 0, 0, 0, 0);
    push_play(0, 0, 0, 1, 0, 0);
    push_play(1, 0, 0, 0, 0, 0);
    push_play(1, 0, 0, 0, 0, 0);
    push_play(1, 0, 1, 0, 0, 0);
    push_play(1, 0, 0, 0, 1, 0);
    push_play(1, 0, 0, 0, 0, 1);
    push_play(0, 1, 0, 0, 1, 1);
    push_play(0, 0, 0, 0, 1, 1);
    // shrink the pattern under the current step, then read past its end
    push_kind(KindRecStart);
    push_rec(1, 0, 0);
    push_play(0, 1, 0, 0, 0, 0);
    push_play(1, 0, 0, 0, 0, 0);
  endtask

  // Driver: advance the request queue, hold the payload while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_view_q.push_back(advance_track(in_data));
        accepted++;
      end
      if (req_q.size() > 0 && !(req_q[0].hold && expected_view_q.size() > 0) &&
          !(req_q[0].phase == 2'd1 && idle_roll(65)) &&
          !(req_q[0].phase == 2'd3 && idle_roll(16))) begin
        next_req    = req_q.pop_front();
        in_valid    <= 1'b1;
        in_data     <= next_req.item;
        drive_phase <= next_req.phase;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest prediction, then roll the stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_view_q.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          error_count++;
        end else begin
          want = expected_view_q.pop_front();
          checked++;
          if (out_data.gate_out !== want.gate_out) begin
            $error("gate_out: expected %0b, got %0b", want.gate_out, out_data.gate_out);
            error_count++;
          end
          if (out_data.play_enabled !== want.play_enabled) begin
            $error("play_enabled: expected %0b, got %0b",
                   want.play_enabled, out_data.play_enabled);
            error_count++;
          end
          if (out_data.current_step !== want.current_step) begin
            $error("current_step: expected %0d, got %0d",
                   want.current_step, out_data.current_step);
            error_count++;
          end
          if (out_data.recorded_steps !== want.recorded_steps) begin
            $error("recorded_steps: expected %0d, got %0d",
                   want.recorded_steps, out_data.recorded_steps);
            error_count++;
          end
        end
      end
      case (drive_phase)
        2'd2:    out_ready <= !idle_roll(65);
        2'd3:    out_ready <= !idle_roll(16);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_view_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MaxSteps; i++) begin
      rise_mem[i] = 1'b0;
      fall_mem[i] = 1'b0;
    end
    trk_len     = '0;
    trk_pos     = '0;
    trk_pend    = 1'b0;
    trk_unmuted = 1'b1;
    trk_gate    = 1'b0;

    fill_phase = 2'd0;
    fill_directed();
    for (int ph = 0; ph < 4; ph++) begin
      fill_phase = 2'(ph);
      // hold off each phase until everything before it has drained
      hold_next = 1'b1;
      fill_random_phase();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() > 0 || in_valid) @(posedge clk_i);
    while (expected_view_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d requests, %0d results checked over four idling phases",
             accepted, checked);
    $display("Saw %0d pattern wraps and %0d record steps rejected on a full pattern",
             wraps, full_rejects);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ gate_step_sequencer_track.f @@
+incdir+src
src/gsst_pkg.sv
src/gsst_in_stage.sv
src/gsst_pat_mem.sv
src/gsst_core.sv
src/gate_step_sequencer_track.sv
src/gsst_checker.sv
bench/gate_step_sequencer_track_tb.sv
